// ===== sv/smm_pkg.sv =====
// Shared types and constants for the square matrix multiply block.
package smm_pkg;

    localparam int MAX_DIM = 8;
    localparam int IDX_W   = 3;
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int DATA_W  = 32;
    localparam int SIZE_W  = 4;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int ACC_W   = PROD_W + 4;
    localparam int FRAC_W  = 16;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_DIM);

    // Command codes of an input item.
    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             issue;
        logic             first;
        logic             final_k;
        logic             last_elem;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] k;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
    } dp_status_t;

endpackage

// ===== sv/square_matrix_multiply_core.sv =====
// Top level of the square matrix multiply block.
//
// Input items arrive on start/command/row/col/value and transfer at a rising
// edge where start is high and busy is low. Command load A or load B writes
// value into that store at (row, col); busy stays low. Command
// compute raises busy and emits the n by n product C = A * B in row-major
// order, n being the clamped size register. Each element is shown for one
// cycle with out_valid high; last marks element (n-1, n-1).
// Each element takes n terms of the single multiply-accumulate unit, one
// read of each store per term; each term passes the store read register,
// the product register and the accumulator, and each element is registered
// at the output. busy falls in the cycle after the last element.
// The size register is written through cfg_valid/cfg_data; cfg_ready is
// always high. Writes are expected only while busy is low.
// Reset sets the size to eight and makes both stores read as zero.
// The receiver takes every element as it is shown and cannot stall it.
module square_matrix_multiply_core
    import smm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        command,
    input  logic [IDX_W-1:0]  row,
    input  logic [IDX_W-1:0]  col,
    input  logic [DATA_W-1:0] value,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SIZE_W-1:0] cfg_data,
    output logic              out_valid,
    output logic [IDX_W-1:0]  out_row,
    output logic [IDX_W-1:0]  out_col,
    output logic [DATA_W-1:0] product_value,
    output logic              saturated,
    output logic              last
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    smm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .command   (command),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .status    (status),
        .busy      (busy),
        .cmd       (cmd)
    );

    smm_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .load_row      (row),
        .load_col      (col),
        .load_value    (value),
        .status        (status),
        .out_valid     (out_valid),
        .out_row       (out_row),
        .out_col       (out_col),
        .product_value (product_value),
        .saturated     (saturated),
        .last          (last)
    );

endmodule

// ===== sv/smm_store.sv =====
// One matrix store: 64 words with per-entry valid bits that read as zero until written.
module smm_store
    import smm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [DATA_W-1:0] rdata_reg;

    // Valid bits are cleared by reset so every entry reads as zero afterwards.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    // Storage array and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= valid_reg[raddr] ? mem_reg[raddr] : '0;
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/smm_ctrl.sv =====
// Controller: size register, command decode and the row/column/term sequencer.
module smm_ctrl
    import smm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        command,
    input  logic              cfg_valid,
    input  logic [SIZE_W-1:0] cfg_data,
    input  dp_status_t        status,
    output logic              busy,
    output dp_cmd_t           cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [IDX_W-1:0]  n_last_reg, n_last_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [IDX_W-1:0]  size_last;
    logic              accept;

    assign accept = start && (state_reg == ST_IDLE);

    // Clamp the configured size into 1..MAX_DIM and keep its last index.
    always_comb
    begin
        if (size_reg == '0)
        begin
            size_last = '0;
        end
        else if (size_reg > SIZE_W'(MAX_DIM))
        begin
            size_last = IDX_W'(MAX_DIM - 1);
        end
        else
        begin
            size_last = IDX_W'(size_reg - SIZE_W'(1));
        end
    end

    // Next state and counter logic.
    always_comb
    begin
        state_next  = state_reg;
        size_next   = size_reg;
        n_last_next = n_last_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        if (cfg_valid)
        begin
            size_next = cfg_data;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && command == CMD_COMPUTE)
                begin
                    n_last_next = size_last;
                    i_next      = '0;
                    j_next      = '0;
                    k_next      = '0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (k_reg != n_last_reg)
                begin
                    k_next = k_reg + IDX_W'(1);
                end
                else
                begin
                    k_next = '0;
                    if (j_reg != n_last_reg)
                    begin
                        j_next = j_reg + IDX_W'(1);
                    end
                    else
                    begin
                        j_next = '0;
                        if (i_reg != n_last_reg)
                        begin
                            i_next = i_reg + IDX_W'(1);
                        end
                        else
                        begin
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                if (status.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, size register and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            size_reg   <= SIZE_RESET;
            n_last_reg <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            size_reg   <= size_next;
            n_last_reg <= n_last_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
        end
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd.wr_a      = accept && (command == CMD_LOAD_A);
        cmd.wr_b      = accept && (command == CMD_LOAD_B);
        cmd.issue     = (state_reg == ST_RUN);
        cmd.first     = (k_reg == '0);
        cmd.final_k   = (k_reg == n_last_reg);
        cmd.last_elem = (i_reg == n_last_reg) && (j_reg == n_last_reg);
        cmd.i         = i_reg;
        cmd.j         = j_reg;
        cmd.k         = k_reg;
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== sv/smm_datapath.sv =====
// Datapath: both stores, the multiply-accumulate pipeline and the saturating result register.
module smm_datapath
    import smm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    input  logic [IDX_W-1:0]  load_row,
    input  logic [IDX_W-1:0]  load_col,
    input  logic [DATA_W-1:0] load_value,
    output dp_status_t        status,
    output logic              out_valid,
    output logic [IDX_W-1:0]  out_row,
    output logic [IDX_W-1:0]  out_col,
    output logic [DATA_W-1:0] product_value,
    output logic              saturated,
    output logic              last
);

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             final_k;
        logic             last_elem;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
    } tag_t;

    logic [DATA_W-1:0]        a_rdata, b_rdata;
    tag_t                     s1_reg, s2_reg, s3_reg;
    tag_t                     s1_next, s3_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-FRAC_W-1:0]  shifted;
    logic                     in_range;
    logic                     out_valid_reg;
    logic [IDX_W-1:0]         out_row_reg, out_col_reg;
    logic [DATA_W-1:0]        value_reg, value_next;
    logic                     sat_reg, sat_next;
    logic                     last_reg;

    // Matrix stores, addressed as row then column.
    smm_store u_store_a (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cmd.wr_a),
        .waddr ({load_row, load_col}),
        .wdata (load_value),
        .raddr ({cmd.i, cmd.k}),
        .rdata (a_rdata)
    );

    smm_store u_store_b (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cmd.wr_b),
        .waddr ({load_row, load_col}),
        .wdata (load_value),
        .raddr ({cmd.k, cmd.j}),
        .rdata (b_rdata)
    );

    always_comb
    begin
        s1_next.valid     = cmd.issue;
        s1_next.first     = cmd.first;
        s1_next.final_k   = cmd.final_k;
        s1_next.last_elem = cmd.last_elem;
        s1_next.i         = cmd.i;
        s1_next.j         = cmd.j;
    end

    // Only the final term of an element moves on to the output stage.
    always_comb
    begin
        s3_next       = s2_reg;
        s3_next.valid = s2_reg.valid && s2_reg.final_k;
    end

    // Product of the two read words, then the exact running sum.
    assign prod_next = $signed(a_rdata) * $signed(b_rdata);
    assign acc_next  = s2_reg.first
                     ? ACC_W'(prod_reg)
                     : acc_reg + ACC_W'(prod_reg);

    // Tags follow the data; control bits are reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            s2_reg        <= '0;
            s3_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_reg        <= s1_next;
            s2_reg        <= s1_reg;
            s3_reg        <= s3_next;
            out_valid_reg <= s3_reg.valid;
        end
    end

    // Scale by the fraction width and clip to the 32-bit range.
    assign shifted  = acc_reg[ACC_W-1:FRAC_W];
    assign in_range = (&shifted[ACC_W-FRAC_W-1:DATA_W-1])
                   || (~|shifted[ACC_W-FRAC_W-1:DATA_W-1]);

    always_comb
    begin
        if (in_range)
        begin
            value_next = shifted[DATA_W-1:0];
            sat_next   = 1'b0;
        end
        else
        begin
            value_next = acc_reg[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                          : {1'b0, {(DATA_W-1){1'b1}}};
            sat_next   = 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (s2_reg.valid)
        begin
            acc_reg <= acc_next;
        end
        out_row_reg <= s3_reg.i;
        out_col_reg <= s3_reg.j;
        value_reg   <= value_next;
        sat_reg     <= sat_next;
        last_reg    <= s3_reg.last_elem;
    end

    assign status.done   = out_valid_reg && last_reg;
    assign out_valid     = out_valid_reg;
    assign out_row       = out_row_reg;
    assign out_col       = out_col_reg;
    assign product_value = value_reg;
    assign saturated     = sat_reg;
    assign last          = last_reg;

endmodule

// ===== sv/smm_checker.sv =====
// Port-level checks of the square matrix multiply block, bound to the top level.
module smm_checker
    import smm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] command,
    input logic       out_valid,
    input logic       last
);

    // Results only appear while a compute item is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> busy)
        else $error("result shown while not busy");

    // The last element ends the compute item.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |=> !busy)
        else $error("busy did not fall after the last element");

    // A compute transfer starts a busy period.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && command == CMD_COMPUTE |=> busy)
        else $error("compute transfer did not raise busy");

    // Loads and unknown commands leave the block idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && command != CMD_COMPUTE |=> !busy && !out_valid)
        else $error("non-compute transfer made the block busy");

endmodule

bind square_matrix_multiply_core smm_checker u_smm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .out_valid (out_valid),
    .last      (last)
);
